@@ design/radix_number_to_symbols_assert.svh @@
// Assertion macros shared by the radix number to symbols design.
`ifndef RADIX_NUMBER_TO_SYMBOLS_ASSERT_SVH
`define RADIX_NUMBER_TO_SYMBOLS_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define RNTS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rnts: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define RNTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rnts: next-cycle check failed");

`endif

@@ design/rnts_pkg.sv @@
// Types, constants and helpers of the radix number to symbols design.
package rnts_pkg;

  localparam int MAX_DIGITS_DEF = 32;
  localparam int MAX_SYMBOLS    = 16;
  localparam int MIN_RADIX      = 2;

  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [4:0]  RADIX_RESET        = 5'd10;
  localparam logic [63:0] SYMBOLS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [63:0] SYMBOLS_HIGH_RESET = 64'h4645444342413938;

  // Divider: quotient bits produced per cycle and divider steps per digit.
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = 32 / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [4:0]       radix;
    logic [15:0][7:0] syms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] number;
    logic        bad;
  } job_t;

  // Symbol configured for one digit value.
  function automatic logic [7:0] sym_at(cfg_t c, logic [3:0] d);
    return c.syms[d];
  endfunction

endpackage

@@ design/rnts_if.sv @@
// Handshake channel interfaces: numbers in, symbols out, configuration writes.
interface rnts_num_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] number;
  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface rnts_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       is_last;
  logic       bad_base;
  modport source (output valid, output symbol, output is_last, output bad_base, input ready);
  modport sink (input valid, input symbol, input is_last, input bad_base, output ready);
endinterface

interface rnts_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/rnts_ram.sv @@
// Generic single write port RAM with registered read.
module rnts_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rnts_front.sv @@
// Front end: configuration registers, base check and number intake.
module rnts_front (
  input  logic             clk,
  input  logic             rst,
  rnts_num_if.sink         num_ch,
  rnts_cfg_if.sink         cfg_ch,
  output logic             job_valid,
  input  logic             job_ready,
  output rnts_pkg::job_t   job,
  output rnts_pkg::cfg_t   cfg
);
  import rnts_pkg::*;

  logic [4:0]  radix;
  logic [63:0] symbols_low;
  logic [63:0] symbols_high;
  logic        base_ok;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= RADIX_RESET;
      symbols_low  <= SYMBOLS_LOW_RESET;
      symbols_high <= SYMBOLS_HIGH_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_RADIX:        radix        <= cfg_ch.data[4:0];
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_ch.data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg.radix = radix;
  assign cfg.syms  = {symbols_high, symbols_low};

  // Base check: radix in range, no sign symbols, no repeated symbols in use.
  always_comb begin
    base_ok = (radix >= 5'(MIN_RADIX)) && (radix <= 5'(MAX_SYMBOLS));
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < radix) begin
        if (cfg.syms[i] == SYM_MINUS || cfg.syms[i] == SYM_PLUS) begin
          base_ok = 1'b0;
        end
        for (int j = i + 1; j < 16; j++) begin
          if (5'(j) < radix && cfg.syms[j] == cfg.syms[i]) begin
            base_ok = 1'b0;
          end
        end
      end
    end
  end

  // Each accepted item goes to the queue tagged with the base check.
  assign job_valid     = num_ch.valid;
  assign num_ch.ready  = job_ready;
  assign job.number    = num_ch.number;
  assign job.bad       = ~base_ok;

endmodule

@@ design/rnts_queue.sv @@
// Two entry queue between the front and back ends.
module rnts_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rnts_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rnts_pkg::job_t pop_data
);
  import rnts_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/rnts_back.sv @@
// Back end: digit divider, digit store and symbol output register.
module rnts_back #(
  parameter int MAX_DIGITS = rnts_pkg::MAX_DIGITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  rnts_pkg::job_t job,
  input  rnts_pkg::cfg_t cfg,
  rnts_sym_if.source     sym_ch
);
  import rnts_pkg::*;
  `include "radix_number_to_symbols_assert.svh"

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]          state;
  logic [31:0]         work;
  logic [3:0]          rem;
  logic [STEP_W-1:0]   step;
  logic [CW-1:0]       count;
  logic [AW-1:0]       idx;
  logic                neg;

  logic                out_valid;
  logic [7:0]          out_symbol;
  logic                out_last;
  logic                out_bad;
  logic                out_free;

  logic [3:0]          rem_next;
  logic [DIV_BITS-1:0] qbits;
  logic [31:0]         work_next;
  logic [CW-1:0]       count_inc;
  logic                digit_done;
  logic                ram_we;
  logic [3:0]          ram_rdata;

  assign out_free  = ~out_valid || sym_ch.ready;
  assign job_ready = (state == S_IDLE) && (~job.bad || out_free);

  // One divider cycle: eight restoring steps over the top byte of the work word.
  always_comb begin
    logic [4:0] trial;
    rem_next = rem;
    qbits    = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      trial = {rem_next, work[31 - b]};
      if (trial >= cfg.radix) begin
        trial = trial - cfg.radix;
        qbits[DIV_BITS - 1 - b] = 1'b1;
      end
      rem_next = trial[3:0];
    end
  end

  assign work_next  = {work[31-DIV_BITS:0], qbits};
  assign count_inc  = count + CW'(1);
  assign digit_done = (state == S_DIV) && (step == STEP_W'(DIV_STEPS - 1));
  assign ram_we     = digit_done;

  rnts_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (rem_next),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Sequencer: convert to digits least significant first, then emit in reverse.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      step      <= '0;
      rem       <= '0;
      idx       <= '0;
      neg       <= 1'b0;
      work      <= '0;
    end else begin
      if (sym_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            if (job.bad) begin
              out_valid  <= 1'b1;
              out_symbol <= '0;
              out_last   <= 1'b1;
              out_bad    <= 1'b1;
            end else begin
              neg   <= job.number[31];
              work  <= job.number[31] ? (32'd0 - job.number) : job.number;
              count <= '0;
              step  <= '0;
              rem   <= '0;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          work <= work_next;
          if (digit_done) begin
            step  <= '0;
            rem   <= '0;
            count <= count_inc;
            if (work_next == 32'd0 || count_inc == CW'(MAX_DIGITS)) begin
              idx   <= count[AW-1:0];
              state <= neg ? S_SIGN : S_RD;
            end
          end else begin
            step <= step + STEP_W'(1);
            rem  <= rem_next;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_symbol <= SYM_MINUS;
            out_last   <= 1'b0;
            out_bad    <= 1'b0;
            state      <= S_RD;
          end
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_symbol <= sym_at(cfg, ram_rdata);
            out_last   <= (idx == '0);
            out_bad    <= 1'b0;
            if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx - AW'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sym_ch.valid    = out_valid;
  assign sym_ch.symbol   = out_symbol;
  assign sym_ch.is_last  = out_last;
  assign sym_ch.bad_base = out_bad;

  // Checks on the sequencer.
  `RNTS_ASSERT_SAME(a_div_room, state == S_DIV, count < CW'(MAX_DIGITS))
  `RNTS_ASSERT_SAME(a_rem_range, state == S_DIV, 5'(rem) < cfg.radix)
  `RNTS_ASSERT_SAME(a_bad_shape, out_valid && out_bad, out_symbol == 8'd0 && out_last)

endmodule

@@ design/radix_number_to_symbols.sv @@
// Top level of the radix number to symbols converter.
//
//   Channel   Direction  Carries
//   num_ch    sink       number (signed 32 bits)
//   sym_ch    source     symbol (8 bits), is_last, bad_base
//   cfg_ch    sink       index (2 bits), data (64 bits): radix, symbols_low, symbols_high
//
// Each digit is divided out at 8 quotient bits a cycle, least significant first; each is then
// emitted through a digit store read state and an output register state, after a minus sign.
// The queue registers each number between the front and back ends.
// Reset is synchronous; it restores radix 10 and symbols "0123456789ABCDEF".
// The two-entry queue lets numbers be taken while the back end converts or stalls.
module radix_number_to_symbols #(
  parameter int MAX_DIGITS = rnts_pkg::MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rnts_num_if.sink   num_ch,
  rnts_sym_if.source sym_ch,
  rnts_cfg_if.sink   cfg_ch
);
  import rnts_pkg::*;

  logic fr_valid;
  logic fr_ready;
  job_t fr_job;
  logic bk_valid;
  logic bk_ready;
  job_t bk_job;
  cfg_t cfg;

  rnts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .num_ch    (num_ch),
    .cfg_ch    (cfg_ch),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job),
    .cfg       (cfg)
  );

  rnts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_job),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_job)
  );

  rnts_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (bk_valid),
    .job_ready (bk_ready),
    .job       (bk_job),
    .cfg       (cfg),
    .sym_ch    (sym_ch)
  );

endmodule

@@ bench/tb.sv @@
// Testbench of the radix number to symbols converter: predicted symbol runs checked item by item.
module tb;
  import rnts_pkg::*;

  localparam int DIGIT_PLACES = MAX_DIGITS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 50;
  localparam int PHASES = 20;
  localparam int NUMBERS_PER_PHASE = 25;

  typedef struct {
    logic [7:0] sym;
    logic       last;
    logic       bad;
  } symbol_out_t;

  logic clk;
  logic rst;

  rnts_num_if num_ch ();
  rnts_sym_if sym_ch ();
  rnts_cfg_if cfg_ch ();

  radix_number_to_symbols i_dut (
    .clk   (clk),
    .rst   (rst),
    .num_ch(num_ch),
    .sym_ch(sym_ch),
    .cfg_ch(cfg_ch)
  );

  // Converter settings as the testbench believes them to be.
  logic [4:0]   cur_radix = RADIX_RESET;
  logic [127:0] cur_alphabet = {SYMBOLS_HIGH_RESET, SYMBOLS_LOW_RESET};

  symbol_out_t pending_symbols[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("timeout: symbols still pending or a handshake never completed");
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch: %s", msg);
  endtask

  // A base is usable when the radix is in range and the symbols in use are
  // distinct and contain no sign character.
  function automatic bit base_ok();
    logic [7:0] s;
    if (cur_radix < MIN_RADIX || cur_radix > MAX_SYMBOLS) return 1'b0;
    for (int i = 0; i < cur_radix; i++) begin
      s = cur_alphabet[8*i +: 8];
      if (s == SYM_MINUS || s == SYM_PLUS) return 1'b0;
      for (int j = i + 1; j < cur_radix; j++)
        if (cur_alphabet[8*j +: 8] == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Works out the symbol run for one number and queues it.
  function automatic void predict_text(input logic [31:0] n);
    logic [3:0]  digits [DIGIT_PLACES];
    logic [31:0] mag;
    logic [31:0] base;
    int          count;
    if (!base_ok()) begin
      pending_symbols.push_back('{sym: 8'h00, last: 1'b1, bad: 1'b1});
      return;
    end
    base = {27'd0, cur_radix};
    mag = n[31] ? 32'd0 - n : n;
    count = 0;
    do begin
      digits[count] = 4'(mag % base);
      mag = mag / base;
      count++;
    end while (mag != 0 && count < DIGIT_PLACES);
    if (n[31]) pending_symbols.push_back('{sym: SYM_MINUS, last: 1'b0, bad: 1'b0});
    for (int i = count - 1; i >= 0; i--)
      pending_symbols.push_back('{sym: cur_alphabet[8*digits[i] +: 8], last: i == 0, bad: 1'b0});
  endfunction

  // Compares one accepted symbol with the oldest one pending.
  task automatic check_symbol();
    symbol_out_t want;
    if (pending_symbols.size() == 0) begin
      report_mismatch($sformatf("symbol %h with nothing pending", sym_ch.symbol));
      return;
    end
    want = pending_symbols.pop_front();
    if (sym_ch.symbol !== want.sym)
      report_mismatch($sformatf("symbol %h, want %h", sym_ch.symbol, want.sym));
    if (sym_ch.is_last !== want.last)
      report_mismatch($sformatf("is_last %b, want %b (symbol %h)", sym_ch.is_last, want.last,
                                want.sym));
    if (sym_ch.bad_base !== want.bad)
      report_mismatch($sformatf("bad_base %b, want %b (symbol %h)", sym_ch.bad_base, want.bad,
                                want.sym));
  endtask

  // Output side: check each accepted item, then decide whether to stall.
  always @(posedge clk) begin
    if (!rst && sym_ch.valid === 1'b1 && sym_ch.ready === 1'b1) check_symbol();
    sym_ch.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // Offers one number, with a random gap first; valid stays high afterwards.
  task automatic send_number(input logic [31:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      num_ch.valid <= 1'b0;
      @(posedge clk);
    end
    predict_text(n);
    num_ch.valid <= 1'b1;
    num_ch.number <= n;
    do @(posedge clk); while (num_ch.ready !== 1'b1);
  endtask

  // Stops offering numbers and waits until every pending symbol has come out.
  task automatic wait_idle();
    num_ch.valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_RADIX:        cur_radix = value[4:0];
      REG_SYMBOLS_LOW:  cur_alphabet[63:0] = value;
      REG_SYMBOLS_HIGH: cur_alphabet[127:64] = value;
      default: ;
    endcase
  endtask

  // Writes all three registers once the converter has gone quiet.
  task automatic apply_config(input logic [4:0] r, input logic [127:0] alphabet);
    logic [63:0] radix_word;
    wait_idle();
    // Bits above the radix field are junk that the block must drop.
    radix_word = {$urandom, $urandom};
    radix_word[4:0] = r;
    write_register(REG_SYMBOLS_LOW, alphabet[63:0]);
    write_register(REG_RADIX, radix_word);
    write_register(REG_SYMBOLS_HIGH, alphabet[127:64]);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 65; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 65; end
      default: begin send_idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  // Sixteen distinct symbols, none of them a sign.
  function automatic logic [127:0] random_alphabet();
    logic [127:0] a;
    logic [7:0]   b;
    bit           used [256];
    used[SYM_MINUS] = 1'b1;
    used[SYM_PLUS] = 1'b1;
    for (int i = 0; i < 16; i++) begin
      do b = 8'($urandom); while (used[b]);
      used[b] = 1'b1;
      a[8*i +: 8] = b;
    end
    return a;
  endfunction

  // Numbers drawn to hit digit boundaries, extremes and short runs as well as
  // the full range.
  function automatic logic [31:0] random_number();
    logic [63:0] p;
    logic [31:0] v;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = 32'($urandom_range(40));
      2: v = $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(40)
                               : 32'h8000_0000 + $urandom_range(40);
      3: begin
        p = 64'd1;
        repeat ($urandom_range(31))
          if (p * cur_radix <= 64'h8000_0000) p = p * cur_radix;
        v = p[31:0] + 32'($urandom_range(2)) - 32'd1;
      end
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(1)) v = 32'd0 - v;
    return v;
  endfunction

  // Conversions with the settings left by reset.
  task automatic test_reset_defaults();
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'hffff_ffff);
    send_number(32'h7fff_ffff);
    send_number(32'h8000_0000);
    send_number(-32'sd10);
  endtask

  // Smallest and largest radix, where runs are longest and shortest.
  task automatic test_radix_extremes();
    apply_config(5'd2, cur_alphabet);
    send_number(32'hffff_ffff);
    send_number(32'h8000_0000);
    send_number(32'h7fff_ffff);
    apply_config(5'd16, random_alphabet());
    send_number(32'h7fff_ffff);
    send_number(32'h8000_0000);
  endtask

  // Bad bases of each kind, symbols past the radix, and a zero byte symbol.
  task automatic test_base_checks();
    logic [127:0] std_alphabet;
    logic [127:0] a;
    std_alphabet = {SYMBOLS_HIGH_RESET, SYMBOLS_LOW_RESET};
    apply_config(5'd0, std_alphabet);
    send_number(32'd5);
    apply_config(5'd1, std_alphabet);
    send_number(-32'sd5);
    apply_config(5'd17, std_alphabet);
    send_number(32'd7);
    apply_config(5'd31, std_alphabet);
    send_number(32'd0);
    // Minus sign on the last symbol in use.
    a = std_alphabet;
    a[8*9 +: 8] = SYM_MINUS;
    apply_config(5'd10, a);
    send_number(32'd12);
    // Plus sign on the first symbol.
    a = std_alphabet;
    a[7:0] = SYM_PLUS;
    apply_config(5'd10, a);
    send_number(-32'sd12);
    // First and last symbol equal.
    a = std_alphabet;
    a[8*15 +: 8] = a[7:0];
    apply_config(5'd16, a);
    send_number(32'd99);
    // Signs and repeats beyond the radix do not matter.
    a = std_alphabet;
    a[8*3 +: 8] = SYM_MINUS;
    a[8*4 +: 8] = SYM_PLUS;
    a[8*5 +: 8] = a[7:0];
    apply_config(5'd3, a);
    send_number(-32'sd100);
    // A zero byte is a normal symbol.
    a = std_alphabet;
    a[7:0] = 8'h00;
    apply_config(5'd4, a);
    send_number(32'd0);
    send_number(32'd64);
  endtask

  // Random settings per phase, mostly valid, with every idling mode in turn.
  task automatic test_random_traffic();
    logic [4:0]   r;
    logic [127:0] a;
    int           i;
    int           j;
    for (int phase = 0; phase < PHASES; phase++) begin
      set_idling(phase % 4);
      r = 5'($urandom_range(2, 16));
      a = random_alphabet();
      if ($urandom_range(2) == 0)
        for (int k = r; k < 16; k++)
          case ($urandom_range(3))
            0: a[8*k +: 8] = SYM_MINUS;
            1: a[8*k +: 8] = SYM_PLUS;
            2: a[8*k +: 8] = a[7:0];
            default: ;
          endcase
      if ($urandom_range(5) == 0)
        case ($urandom_range(2))
          0: r = $urandom_range(1) ? 5'($urandom_range(1)) : 5'($urandom_range(17, 31));
          1: a[8*$urandom_range(r - 1) +: 8] = $urandom_range(1) ? SYM_MINUS : SYM_PLUS;
          default: begin
            j = $urandom_range(r - 1);
            i = (j + 1 + $urandom_range(r - 2)) % r;
            a[8*i +: 8] = a[8*j +: 8];
          end
        endcase
      apply_config(r, a);
      repeat (NUMBERS_PER_PHASE) send_number(random_number());
    end
  endtask

  initial begin
    rst <= 1'b1;
    num_ch.valid <= 1'b0;
    num_ch.number <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_RADIX;
    cfg_ch.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_idling(0);
    test_reset_defaults();
    test_radix_extremes();
    test_base_checks();
    test_random_traffic();

    // Drain, then watch a while longer for stray items.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_symbols.size() != 0)
      report_mismatch($sformatf("%0d symbols never arrived", pending_symbols.size()));
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
